[hw/rtl/mss_pkg.sv]
// -----------------------------------------------------------------------------
// mss_pkg: shared types and constants for the marker scan segment extractor
// Holds item kind codes, phase type, marker bytes, window control and status
// structs, and the case folding helper used by the window and the control.
// -----------------------------------------------------------------------------
package mss_pkg;

    // Window geometry
    localparam int WIN_LEN    = 18;
    localparam int MARK_FIRST = 12;
    localparam int HEAD_LEN   = 5;

    // Input item kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_NEW   = 2'd1;
    localparam logic [1:0] KIND_EOF   = 2'd2;
    localparam logic [1:0] KIND_NONE  = 2'd3;

    // Result kinds
    localparam logic [1:0] OUT_PAYLOAD = 2'd0;
    localparam logic [1:0] OUT_START   = 2'd1;
    localparam logic [1:0] OUT_BAD_HDR = 2'd2;
    localparam logic [1:0] OUT_EARLY   = 2'd3;

    // Header count once the whole header has matched
    localparam logic [2:0] HEAD_DONE = 3'd5;

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_SCAN   = 2'd1,
        PH_COPY   = 2'd2,
        PH_HALT   = 2'd3
    } phase_t;

    // Control from the sequencer to the window chain
    typedef struct packed {
        logic shift;
        logic clear;
    } win_ctrl_t;

    // Status from the window chain to the sequencer
    typedef struct packed {
        logic        hit;
        logic [23:0] length;
    } win_stat_t;

    // Fold lower case ASCII letters to upper case
    function automatic logic [7:0] fold_case(input logic [7:0] b);
        logic [7:0] r;
        r = b;
        if (b >= 8'h61 && b <= 8'h7A)
        begin
            r = b - 8'h20;
        end
        return r;
    endfunction

    // Header bytes "SFW95"; positions past the header give zero
    function automatic logic [7:0] head_byte(input logic [2:0] pos);
        logic [7:0] r;
        unique case (pos)
            3'd0:    r = 8'h53;
            3'd1:    r = 8'h46;
            3'd2:    r = 8'h57;
            3'd3:    r = 8'h39;
            3'd4:    r = 8'h35;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    // Segment marker bytes "SFW94A"
    function automatic logic [7:0] mark_byte(input logic [2:0] pos);
        logic [7:0] r;
        unique case (pos)
            3'd0:    r = 8'h53;
            3'd1:    r = 8'h46;
            3'd2:    r = 8'h57;
            3'd3:    r = 8'h39;
            3'd4:    r = 8'h34;
            3'd5:    r = 8'h41;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

endpackage

[hw/rtl/mss_cell.sv]
// -----------------------------------------------------------------------------
// mss_cell: one byte cell of the scan window chain
// Takes its neighbor's byte on shift and drops to zero on clear.
// -----------------------------------------------------------------------------
module mss_cell
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mss_pkg::win_ctrl_t    ctrl,
    input  logic [7:0]            d,
    output logic [7:0]            q
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    // Clear wins over shift
    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.clear)
        begin
            byte_next = 8'h00;
        end
        else if (ctrl.shift)
        begin
            byte_next = d;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= 8'h00;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign q = byte_reg;

endmodule

[hw/rtl/mss_window.sv]
// -----------------------------------------------------------------------------
// mss_window: sliding byte window built from a row of cells
// Shifts the incoming byte in at the newest end, and reports whether the
// window after this shift ends in the segment marker, plus the length
// held in its three oldest bytes.
// -----------------------------------------------------------------------------
module mss_window
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  mss_pkg::win_ctrl_t    ctrl,
    input  logic [7:0]            data_byte,
    output mss_pkg::win_stat_t    stat
);

    localparam int N    = mss_pkg::WIN_LEN;
    localparam int MARK = mss_pkg::MARK_FIRST;

    logic [7:0] q   [N];
    logic [7:0] nxt [N];
    logic [5:0] cmp;

    // Chain cells: each takes its newer neighbor, the newest takes the input
    genvar gi;
    generate
        for (gi = 0; gi < N; gi++)
        begin : g_cell
            if (gi == N - 1)
            begin : g_head
                assign nxt[gi] = data_byte;
            end
            else
            begin : g_link
                assign nxt[gi] = q[gi + 1];
            end
            mss_cell u_cell
            (
                .clk   (clk),
                .rst_n (rst_n),
                .ctrl  (ctrl),
                .d     (nxt[gi]),
                .q     (q[gi])
            );
        end
    endgenerate

    // Compare the post-shift newest six bytes against the marker
    always_comb
    begin
        for (int k = 0; k < 6; k++)
        begin
            cmp[k] = (mss_pkg::fold_case(nxt[MARK + k]) == mss_pkg::mark_byte(3'(k)));
        end
    end

    // Length in the post-shift oldest three bytes, little endian
    assign stat.hit    = &cmp;
    assign stat.length = {nxt[2], nxt[1], nxt[0]};

endmodule

[hw/rtl/marker_scan_segment_extractor.sv]
// -----------------------------------------------------------------------------
// marker_scan_segment_extractor: container splitter with marker scan
// Checks the file header, scans for the segment marker in a sliding window,
// emits a segment start with the length, then passes the payload bytes.
// -----------------------------------------------------------------------------
// The result of an accepted beat is loaded into the output register.
// Throughput: one beat per cycle; the only hold-off is a stalled full output
// register, since the window chain and the byte counter never hold a beat.
// Reset: asynchronous, active low; returns to header check with a zero window
// and an empty output register. No clearing pass is needed.
module marker_scan_segment_extractor
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [1:0]  out_kind,
    output logic [7:0]  out_byte,
    output logic [23:0] segment_length,
    output logic        last_of_segment
);

    mss_pkg::phase_t    phase_reg, phase_next;
    logic [2:0]         hpos_reg, hpos_next;
    logic [23:0]        rem_reg, rem_next;
    logic [23:0]        rem_dec;

    logic               ov_reg, ov_next;
    logic [1:0]         okind_reg;
    logic [7:0]         obyte_reg;
    logic [23:0]        olen_reg;
    logic               olast_reg;

    logic               acc;
    mss_pkg::phase_t    eff_phase;
    logic [2:0]         eff_hpos;
    logic               head_ok;

    logic               res_valid;
    logic [1:0]         res_kind;
    logic [7:0]         res_byte;
    logic [23:0]        res_len;
    logic               res_last;

    mss_pkg::win_ctrl_t win_ctrl;
    mss_pkg::win_stat_t win_stat;

    // Accept whenever the output register is empty or being drained
    assign in_stall = ov_reg && out_stall;
    assign acc      = in_valid && !in_stall;

    // A new file mark restarts the header check on this very byte
    assign eff_phase = (kind == mss_pkg::KIND_NEW) ? mss_pkg::PH_HEADER : phase_reg;
    assign eff_hpos  = (kind == mss_pkg::KIND_NEW) ? 3'd0 : hpos_reg;
    assign head_ok   = (eff_hpos < 3'(mss_pkg::HEAD_LEN))
                    && (mss_pkg::fold_case(data_byte) == mss_pkg::head_byte(eff_hpos));
    assign rem_dec   = rem_reg - 24'd1;

    mss_window u_window
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (win_ctrl),
        .data_byte (data_byte),
        .stat      (win_stat)
    );

    // Next state of phase, header count and byte counter
    always_comb
    begin
        phase_next = phase_reg;
        hpos_next  = hpos_reg;
        rem_next   = rem_reg;
        if (acc && kind != mss_pkg::KIND_NONE)
        begin
            if (kind == mss_pkg::KIND_EOF)
            begin
                phase_next = mss_pkg::PH_HALT;
            end
            else
            begin
                phase_next = eff_phase;
                hpos_next  = eff_hpos;
                unique case (eff_phase)
                    mss_pkg::PH_HEADER:
                    begin
                        if (!head_ok)
                        begin
                            phase_next = mss_pkg::PH_HALT;
                        end
                        else
                        begin
                            hpos_next = eff_hpos + 3'd1;
                            if (hpos_next == mss_pkg::HEAD_DONE)
                            begin
                                phase_next = mss_pkg::PH_SCAN;
                                rem_next   = 24'd0;
                            end
                        end
                    end
                    mss_pkg::PH_SCAN:
                    begin
                        if (win_stat.hit && win_stat.length != 24'd0)
                        begin
                            rem_next   = win_stat.length;
                            phase_next = mss_pkg::PH_COPY;
                        end
                    end
                    mss_pkg::PH_COPY:
                    begin
                        rem_next = rem_dec;
                        if (rem_dec == 24'd0)
                        begin
                            phase_next = mss_pkg::PH_SCAN;
                        end
                    end
                    mss_pkg::PH_HALT:
                    begin
                        phase_next = mss_pkg::PH_HALT;
                    end
                endcase
            end
        end
    end

    // Result of this beat and window control
    always_comb
    begin
        res_valid      = 1'b0;
        res_kind       = mss_pkg::OUT_PAYLOAD;
        res_byte       = 8'h00;
        res_len        = 24'd0;
        res_last       = 1'b0;
        win_ctrl.shift = 1'b0;
        win_ctrl.clear = 1'b0;
        if (acc && kind != mss_pkg::KIND_NONE)
        begin
            if (kind == mss_pkg::KIND_EOF)
            begin
                if (phase_reg != mss_pkg::PH_HALT)
                begin
                    res_valid = 1'b1;
                    res_kind  = mss_pkg::OUT_EARLY;
                end
            end
            else
            begin
                unique case (eff_phase)
                    mss_pkg::PH_HEADER:
                    begin
                        if (!head_ok)
                        begin
                            res_valid = 1'b1;
                            res_kind  = mss_pkg::OUT_BAD_HDR;
                        end
                        else if (eff_hpos + 3'd1 == mss_pkg::HEAD_DONE)
                        begin
                            win_ctrl.clear = 1'b1;
                        end
                    end
                    mss_pkg::PH_SCAN:
                    begin
                        win_ctrl.shift = 1'b1;
                        if (win_stat.hit)
                        begin
                            res_valid = 1'b1;
                            res_kind  = mss_pkg::OUT_START;
                            res_len   = win_stat.length;
                            if (win_stat.length == 24'd0)
                            begin
                                res_last       = 1'b1;
                                win_ctrl.clear = 1'b1;
                            end
                        end
                    end
                    mss_pkg::PH_COPY:
                    begin
                        res_valid = 1'b1;
                        res_kind  = mss_pkg::OUT_PAYLOAD;
                        res_byte  = data_byte;
                        if (rem_dec == 24'd0)
                        begin
                            res_last       = 1'b1;
                            win_ctrl.clear = 1'b1;
                        end
                    end
                    mss_pkg::PH_HALT:
                    begin
                        res_valid = 1'b0;
                    end
                endcase
            end
        end
    end

    // Output register: load on accept, drain when not stalled
    always_comb
    begin
        ov_next = ov_reg;
        if (acc)
        begin
            ov_next = res_valid;
        end
        else if (!out_stall)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= mss_pkg::PH_HEADER;
            hpos_reg  <= 3'd0;
            rem_reg   <= 24'd0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            hpos_reg  <= hpos_next;
            rem_reg   <= rem_next;
            ov_reg    <= ov_next;
        end
    end

    // Hold the payload of the output beat
    always_ff @(posedge clk)
    begin
        if (acc && res_valid)
        begin
            okind_reg <= res_kind;
            obyte_reg <= res_byte;
            olen_reg  <= res_len;
            olast_reg <= res_last;
        end
    end

    assign out_valid       = ov_reg;
    assign out_kind        = okind_reg;
    assign out_byte        = obyte_reg;
    assign segment_length  = olen_reg;
    assign last_of_segment = olast_reg;

    // The copy phase always has bytes left to pass
    a_copy_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == mss_pkg::PH_COPY |-> rem_reg != 24'd0)
        else $error("copy phase with zero bytes remaining");

    // Scan and copy are reached only through a complete header
    a_scan_after_header: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == mss_pkg::PH_SCAN || phase_reg == mss_pkg::PH_COPY)
        |-> hpos_reg == mss_pkg::HEAD_DONE)
        else $error("scan or copy without a matched header");

    // A start beat marked last carries a zero length
    a_start_last_len: assert property (@(posedge clk) disable iff (!rst_n)
        ov_reg && okind_reg == mss_pkg::OUT_START && olast_reg |-> olen_reg == 24'd0)
        else $error("last-marked segment start with nonzero length");

    // An undefined kind leaves the state untouched and yields nothing
    a_none_kind: assert property (@(posedge clk) disable iff (!rst_n)
        acc && kind == mss_pkg::KIND_NONE
        |=> phase_reg == $past(phase_reg) && rem_reg == $past(rem_reg) && !ov_reg)
        else $error("undefined kind changed state or produced a result");

endmodule
